// ===== hw/rtl/euler_angle_shortest_blend_defines.svh =====
// Assertion macros for the euler_angle_shortest_blend block.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef EULER_ANGLE_SHORTEST_BLEND_DEFINES_SVH
`define EULER_ANGLE_SHORTEST_BLEND_DEFINES_SVH

`ifndef SYNTHESIS
`define EASB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("easb: assertion failed");
`define EASB_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("easb: sequencing assertion failed");
`else
`define EASB_ASSERT(lbl, prop)
`define EASB_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== hw/rtl/easb_pkg.sv =====
// Package for euler_angle_shortest_blend: angle constants, widths and lane math.
// No dependencies.
`timescale 1ns / 1ps

package easb_pkg;

  localparam int LANE_W  = 16;
  localparam int DELTA_W = 18;
  localparam int WRAP_W  = 13;
  localparam int LERP_W  = 17;
  localparam int WGT_W   = 9;
  localparam int ABS_W   = 12;
  localparam int SUM_W   = 14;
  localparam int PROD_W  = LERP_W + WGT_W + 1;
  localparam int SHIFT   = 8;

  typedef logic signed [LANE_W-1:0]  lane_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [WRAP_W-1:0]  wrap_t;
  typedef logic signed [LERP_W-1:0]  lerp_t;
  typedef logic        [WGT_W-1:0]   wgt_t;
  typedef logic        [ABS_W-1:0]   mag_t;
  typedef logic        [SUM_W-1:0]   sum_t;

  localparam delta_t HALF_TURN   = 18'sd2048;
  localparam delta_t NEG_HALF    = -18'sd2048;
  localparam wrap_t  HALF_M1_W   = 13'sd2047;
  localparam wrap_t  HALF_W      = 13'sd2048;
  localparam logic [11:0] TURN_LO_M1 = 12'd2047;
  localparam logic [11:0] TURN_LO_H  = 12'h800;
  localparam logic [15:0] WEIGHT_ONE = 16'h0100;

  typedef enum logic {
    CMD_EULER = 1'b0,
    CMD_LERP  = 1'b1
  } cmd_t;

  // Reduce a delta by whole turns (4096) into [-2048, 2048].
  function automatic wrap_t wrap_turn(input delta_t d);
    logic [11:0] lo;
    wrap_t       r;
    lo = '0;
    if (d > HALF_TURN) begin
      lo = d[11:0] + TURN_LO_M1;
      r  = $signed({1'b0, lo}) - HALF_M1_W;
    end else if (d < NEG_HALF) begin
      lo = d[11:0] ^ TURN_LO_H;
      r  = $signed({1'b0, lo}) - HALF_W;
    end else begin
      r  = d[WRAP_W-1:0];
    end
    return r;
  endfunction

  function automatic mag_t mag(input wrap_t v);
    wrap_t n;
    n = -v;
    return v[WRAP_W-1] ? n[ABS_W-1:0] : v[ABS_W-1:0];
  endfunction

  // start + floor(delta * w / 256), low 16 bits.
  function automatic lane_t lane_blend(input lane_t s, input lerp_t d, input wgt_t w);
    logic signed [PROD_W-1:0] p;
    p = $signed(d) * $signed({1'b0, w});
    return s + $signed(p[SHIFT+LANE_W-1:SHIFT]);
  endfunction

endpackage

// ===== hw/rtl/euler_angle_shortest_blend.sv =====
// Top level of euler_angle_shortest_blend: input register, blend logic, result register.
// Depends on easb_pkg and euler_angle_shortest_blend_defines.svh.
//
//  channel | ports                                   | dir
//  --------+-----------------------------------------+-----
//  input   | in_valid/in_ready, in_cmd, in_start_*,  | in
//          | in_end_*, in_weight                     |
//  result  | out_valid/out_ready, out_x/out_y/out_z  | out
//
// One transaction per cycle when out_ready is high, via the input register, then
// the result register. The path between them is the wrap, L1 compare and 17x10
// multiply per lane. Reset clears both valid flags only. A stalled result holds
// the result register; the input register keeps accepting until it is also full.
`timescale 1ns / 1ps
`include "euler_angle_shortest_blend_defines.svh"

module euler_angle_shortest_blend (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic signed [15:0]  in_start_x,
  input  logic signed [15:0]  in_start_y,
  input  logic signed [15:0]  in_start_z,
  input  logic signed [15:0]  in_end_x,
  input  logic signed [15:0]  in_end_y,
  input  logic signed [15:0]  in_end_z,
  input  logic        [15:0]  in_weight,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_x,
  output logic signed [15:0]  out_y,
  output logic signed [15:0]  out_z
);

  logic               s1_valid_r;
  easb_pkg::cmd_t     cmd_r;
  easb_pkg::lane_t    sx_r, sy_r, sz_r, ex_r, ey_r, ez_r;
  logic [15:0]        weight_r;

  logic               out_valid_r;
  easb_pkg::lane_t    ox_r, oy_r, oz_r;
  easb_pkg::lane_t    ox_nxt, oy_nxt, oz_nxt;

  logic               out_load;
  logic               in_load;

  easb_pkg::wgt_t     w_clamp;
  easb_pkg::delta_t   dx, dy, dz, fx, fy, fz;
  easb_pkg::wrap_t    wdx, wdy, wdz, wfx, wfy, wfz;
  easb_pkg::wrap_t    selx, sely, selz;
  easb_pkg::sum_t     sum_d, sum_f;
  logic               use_flip;
  easb_pkg::lerp_t    lx, ly, lz;
  logic               sel_ok;

  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || !out_valid_r || out_ready;
  assign in_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      cmd_r    <= easb_pkg::cmd_t'(in_cmd);
      sx_r     <= in_start_x;
      sy_r     <= in_start_y;
      sz_r     <= in_start_z;
      ex_r     <= in_end_x;
      ey_r     <= in_end_y;
      ez_r     <= in_end_z;
      weight_r <= in_weight;
    end
  end

  always_comb begin
    w_clamp = (weight_r > easb_pkg::WEIGHT_ONE) ? easb_pkg::WEIGHT_ONE[8:0]
                                                : weight_r[8:0];
    dx = 18'(ex_r) - 18'(sx_r);
    dy = 18'(ey_r) - 18'(sy_r);
    dz = 18'(ez_r) - 18'(sz_r);
    fx = 18'(ex_r) + easb_pkg::HALF_TURN - 18'(sx_r);
    fy = easb_pkg::HALF_TURN - 18'(ey_r) - 18'(sy_r);
    fz = 18'(ez_r) + easb_pkg::HALF_TURN - 18'(sz_r);
    wdx = easb_pkg::wrap_turn(dx);
    wdy = easb_pkg::wrap_turn(dy);
    wdz = easb_pkg::wrap_turn(dz);
    wfx = easb_pkg::wrap_turn(fx);
    wfy = easb_pkg::wrap_turn(fy);
    wfz = easb_pkg::wrap_turn(fz);
    sum_d = 14'(easb_pkg::mag(wdx)) + 14'(easb_pkg::mag(wdy)) + 14'(easb_pkg::mag(wdz));
    sum_f = 14'(easb_pkg::mag(wfx)) + 14'(easb_pkg::mag(wfy)) + 14'(easb_pkg::mag(wfz));
    use_flip = sum_f < sum_d;
    selx = use_flip ? wfx : wdx;
    sely = use_flip ? wfy : wdy;
    selz = use_flip ? wfz : wdz;
    unique case (cmd_r)
      easb_pkg::CMD_LERP: begin
        lx = dx[16:0];
        ly = dy[16:0];
        lz = dz[16:0];
      end
      easb_pkg::CMD_EULER: begin
        lx = 17'(selx);
        ly = 17'(sely);
        lz = 17'(selz);
      end
      default: begin
        lx = dx[16:0];
        ly = dy[16:0];
        lz = dz[16:0];
      end
    endcase
    ox_nxt = easb_pkg::lane_blend(sx_r, lx, w_clamp);
    oy_nxt = easb_pkg::lane_blend(sy_r, ly, w_clamp);
    oz_nxt = easb_pkg::lane_blend(sz_r, lz, w_clamp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      oz_r <= oz_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_z     = oz_r;

  assign sel_ok = (selx <= 13'sd2048) && (selx >= -13'sd2048) &&
                  (sely <= 13'sd2048) && (sely >= -13'sd2048) &&
                  (selz <= 13'sd2048) && (selz >= -13'sd2048);

  `EASB_ASSERT(a_backpressure_full, !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
  `EASB_ASSERT_NEXT(a_stage_advance, out_load, out_valid_r)
  `EASB_ASSERT(a_wrap_range, (s1_valid_r && cmd_r == easb_pkg::CMD_EULER) |-> sel_ok)
  `EASB_ASSERT_NEXT(a_hold_full, (s1_valid_r && out_valid_r && !out_ready), s1_valid_r)

endmodule

// ===== sim/tb_euler_angle_shortest_blend.sv =====
// Testbench for euler_angle_shortest_blend: a directed table, then random transactions
// under bursty input and stalled output, checked against a local blend predictor or
// a known table result. Depends on easb_pkg and the euler_angle_shortest_blend RTL.
`timescale 1ns / 1ps

module tb_euler_angle_shortest_blend;

  localparam int ANGLE_HALF  = 2048;
  localparam int ANGLE_TURN  = 4096;
  localparam int WEIGHT_FULL = 256;
  localparam int N_RANDOM    = 1050;
  localparam int CYCLE_LIMIT = 250000;
  localparam int N_DIRECTED  = 22;

  typedef struct packed {
    easb_pkg::cmd_t  cmd;
    easb_pkg::lane_t sx, sy, sz;
    easb_pkg::lane_t ex, ey, ez;
    logic [15:0]     weight;
  } blend_req_t;

  typedef struct packed {
    easb_pkg::lane_t x, y, z;
  } blend_res_t;

  typedef struct packed {
    blend_req_t req;
    logic       known;
    blend_res_t res;
  } table_row_t;

  localparam table_row_t DIRECTED [N_DIRECTED] = '{
    '{'{easb_pkg::CMD_LERP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0},
      1'b1, '{16'sd0, 16'sd0, 16'sd0}},
    '{'{easb_pkg::CMD_LERP, 16'sd100, -16'sd200, 16'sd300, 16'sd1000, 16'sd2000,
        -16'sd3000, 16'd0},
      1'b1, '{16'sd100, -16'sd200, 16'sd300}},
    '{'{easb_pkg::CMD_LERP, 16'sd100, -16'sd200, 16'sd300, 16'sd1000, 16'sd2000,
        -16'sd3000, 16'd256},
      1'b1, '{16'sd1000, 16'sd2000, -16'sd3000}},
    '{'{easb_pkg::CMD_LERP, 16'sd100, -16'sd200, 16'sd300, 16'sd1000, 16'sd2000,
        -16'sd3000, 16'd65535},
      1'b1, '{16'sd1000, 16'sd2000, -16'sd3000}},
    '{'{easb_pkg::CMD_LERP, -16'sd32768, -16'sd32768, 16'sd32767,
        16'sd32767, 16'sd32767, -16'sd32768, 16'd256},
      1'b1, '{16'sd32767, 16'sd32767, -16'sd32768}},
    '{'{easb_pkg::CMD_LERP, -16'sd32768, -16'sd32768, 16'sd32767,
        16'sd32767, 16'sd32767, -16'sd32768, 16'd128},
      1'b0, '0},
    '{'{easb_pkg::CMD_LERP, 16'sd0, 16'sd0, 16'sd0, -16'sd1, -16'sd1, -16'sd1, 16'd1},
      1'b0, '0},
    '{'{easb_pkg::CMD_EULER, 16'sd1000, -16'sd500, 16'sd32767,
        -16'sd32768, 16'sd7000, -16'sd1, 16'd0},
      1'b1, '{16'sd1000, -16'sd500, 16'sd32767}},
    '{'{easb_pkg::CMD_EULER, 16'sd0, 16'sd0, 16'sd0, 16'sd2048, 16'sd0, 16'sd0, 16'd256},
      1'b0, '0},
    '{'{easb_pkg::CMD_EULER, 16'sd0, 16'sd0, 16'sd0, -16'sd2048, 16'sd0, 16'sd0, 16'd256},
      1'b0, '0},
    '{'{easb_pkg::CMD_EULER, 16'sd0, 16'sd0, 16'sd0, 16'sd1024, 16'sd1024, 16'sd1024,
        16'd256},
      1'b0, '0},
    '{'{easb_pkg::CMD_EULER, 16'sd0, 16'sd0, 16'sd0, 16'sd2048, 16'sd0, 16'sd2048,
        16'd256},
      1'b0, '0},
    '{'{easb_pkg::CMD_EULER, 16'sd32767, 16'sd32767, 16'sd32767,
        -16'sd32768, -16'sd32768, -16'sd32768, 16'd256},
      1'b0, '0},
    '{'{easb_pkg::CMD_EULER, -16'sd32768, -16'sd32768, -16'sd32768,
        16'sd32767, 16'sd32767, 16'sd32767, 16'd256},
      1'b0, '0},
    '{'{easb_pkg::CMD_EULER, 16'sd0, 16'sd0, 16'sd0, -16'sd3, 16'sd5, -16'sd700, 16'd100},
      1'b0, '0},
    '{'{easb_pkg::CMD_EULER, 16'sd10, 16'sd20, 16'sd30, 16'sd4000, -16'sd4000, 16'sd100,
        16'd257},
      1'b0, '0},
    '{'{easb_pkg::CMD_EULER, 16'sd10, 16'sd20, 16'sd30, 16'sd4000, -16'sd4000, 16'sd100,
        16'd65535},
      1'b0, '0},
    '{'{easb_pkg::CMD_EULER, 16'sd0, 16'sd0, 16'sd0, 16'sd2049, 16'sd0, 16'sd0, 16'd256},
      1'b0, '0},
    '{'{easb_pkg::CMD_EULER, 16'sd0, 16'sd0, 16'sd0, -16'sd2049, 16'sd0, 16'sd0, 16'd256},
      1'b0, '0},
    '{'{easb_pkg::CMD_LERP, 16'sd32767, -16'sd32768, 16'sd0, 16'sd32767, -16'sd32768,
        16'sd0, 16'd200},
      1'b1, '{16'sd32767, -16'sd32768, 16'sd0}},
    '{'{easb_pkg::CMD_EULER, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd65535},
      1'b1, '{16'sd0, 16'sd0, 16'sd0}},
    '{'{easb_pkg::CMD_EULER, 16'sd0, 16'sd0, 16'sd0, 16'sd2048, 16'sd2048, 16'sd2048,
        16'd256},
      1'b0, '0}
  };

  logic            clk;
  logic            rst_n       = 1'b0;
  logic            in_valid    = 1'b0;
  logic            in_ready;
  logic            in_cmd      = 1'b0;
  easb_pkg::lane_t in_start_x  = '0;
  easb_pkg::lane_t in_start_y  = '0;
  easb_pkg::lane_t in_start_z  = '0;
  easb_pkg::lane_t in_end_x    = '0;
  easb_pkg::lane_t in_end_y    = '0;
  easb_pkg::lane_t in_end_z    = '0;
  logic [15:0]     in_weight   = '0;
  logic            out_valid;
  logic            out_ready   = 1'b0;
  easb_pkg::lane_t out_x, out_y, out_z;

  blend_res_t  blend_q[$];
  int          errors      = 0;
  int          cycles      = 0;
  int          rx_mode     = 0;
  int          rx_count    = 0;
  int          burst_left  = 0;
  bit          no_gaps     = 1'b0;

  euler_angle_shortest_blend u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_start_z (in_start_z),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .in_end_z   (in_end_z),
    .in_weight  (in_weight),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reduce a delta by whole turns; +-half turn stays as is
  function automatic int turn_wrap(input int d);
    int r;
    r = d;
    if (d > ANGLE_HALF) begin
      r = (d + ANGLE_HALF - 1) % ANGLE_TURN;
      if (r < 0) r += ANGLE_TURN;
      r = r - (ANGLE_HALF - 1);
    end else if (d < -ANGLE_HALF) begin
      r = (d + ANGLE_HALF) % ANGLE_TURN;
      if (r < 0) r += ANGLE_TURN;
      r = r - ANGLE_HALF;
    end
    return r;
  endfunction

  function automatic int abs_int(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic blend_res_t blend_predict(input blend_req_t rq);
    int         s[3];
    int         e[3];
    int         dd[3];
    int         fd[3];
    int         lane[3];
    int         w;
    int         sum_d;
    int         sum_f;
    blend_res_t r;
    s[0] = rq.sx; s[1] = rq.sy; s[2] = rq.sz;
    e[0] = rq.ex; e[1] = rq.ey; e[2] = rq.ez;
    w = (rq.weight > WEIGHT_FULL) ? WEIGHT_FULL : int'(rq.weight);
    sum_d = 0;
    sum_f = 0;
    if (rq.cmd == easb_pkg::CMD_LERP) begin
      for (int k = 0; k < 3; k++) dd[k] = e[k] - s[k];
    end else begin
      for (int k = 0; k < 3; k++) begin
        dd[k] = turn_wrap(e[k] - s[k]);
        sum_d += abs_int(dd[k]);
      end
      // flipped equivalent: (x + half, half - y, z + half)
      fd[0] = turn_wrap(e[0] + ANGLE_HALF - s[0]);
      fd[1] = turn_wrap(ANGLE_HALF - e[1] - s[1]);
      fd[2] = turn_wrap(e[2] + ANGLE_HALF - s[2]);
      for (int k = 0; k < 3; k++) sum_f += abs_int(fd[k]);
      if (sum_f < sum_d) begin
        for (int k = 0; k < 3; k++) dd[k] = fd[k];
      end
    end
    for (int k = 0; k < 3; k++) lane[k] = s[k] + ((dd[k] * w) >>> 8);
    r.x = easb_pkg::lane_t'(lane[0]);
    r.y = easb_pkg::lane_t'(lane[1]);
    r.z = easb_pkg::lane_t'(lane[2]);
    return r;
  endfunction

  function automatic easb_pkg::lane_t pick_angle();
    easb_pkg::lane_t a;
    case ($urandom_range(0, 3))
      0: a = easb_pkg::lane_t'($urandom);
      1: a = easb_pkg::lane_t'(int'($urandom_range(0, 8191)) - ANGLE_TURN);
      2: a = easb_pkg::lane_t'(ANGLE_HALF * int'($urandom_range(0, 31)) - 32768
                               + int'($urandom_range(0, 6)) - 3);
      default: begin
        case ($urandom_range(0, 3))
          0: a = 16'sh7fff;
          1: a = 16'sh8000;
          2: a = 16'sh0000;
          default: a = 16'shffff;
        endcase
      end
    endcase
    return a;
  endfunction

  // end angle offset from the start, often near a wrap boundary; else a random angle
  function automatic easb_pkg::lane_t pick_end(input easb_pkg::lane_t s);
    int off;
    case ($urandom_range(0, 3))
      0: off = int'($urandom_range(0, 12287)) - 6144;
      1: off = (($urandom_range(0, 1) != 0) ? ANGLE_HALF : -ANGLE_HALF)
               + int'($urandom_range(0, 4)) - 2;
      2: off = ANGLE_TURN * (int'($urandom_range(0, 8)) - 4) + int'($urandom_range(0, 2048))
               - 1024;
      default: return pick_angle();
    endcase
    return easb_pkg::lane_t'(int'(s) + off);
  endfunction

  function automatic blend_req_t random_req();
    blend_req_t rq;
    rq.cmd = ($urandom_range(0, 3) == 0) ? easb_pkg::CMD_LERP : easb_pkg::CMD_EULER;
    rq.sx = pick_angle();
    rq.sy = pick_angle();
    rq.sz = pick_angle();
    rq.ex = pick_end(rq.sx);
    rq.ey = ($urandom_range(0, 3) == 0) ? easb_pkg::lane_t'(ANGLE_HALF - int'(rq.sy)
              + int'($urandom_range(0, 4)) - 2) : pick_end(rq.sy);
    rq.ez = pick_end(rq.sz);
    case ($urandom_range(0, 4))
      0, 1: rq.weight = 16'($urandom_range(0, WEIGHT_FULL));
      2: rq.weight = 16'($urandom_range(WEIGHT_FULL + 1, 65535));
      3: rq.weight = ($urandom_range(0, 1) != 0) ? 16'(WEIGHT_FULL) : 16'd0;
      default: rq.weight = 16'($urandom);
    endcase
    return rq;
  endfunction

  task automatic idle_gap();
    if (!no_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      in_weight <= 16'($urandom);
      in_start_x <= easb_pkg::lane_t'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_req(input blend_req_t rq, input logic known, input blend_res_t want);
    idle_gap();
    in_valid   <= 1'b1;
    in_cmd     <= rq.cmd;
    in_start_x <= rq.sx;
    in_start_y <= rq.sy;
    in_start_z <= rq.sz;
    in_end_x   <= rq.ex;
    in_end_y   <= rq.ey;
    in_end_z   <= rq.ez;
    in_weight  <= rq.weight;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    blend_q.push_back(known ? want : blend_predict(rq));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (blend_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stim
    blend_req_t rq;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIRECTED; i++)
      send_req(DIRECTED[i].req, DIRECTED[i].known, DIRECTED[i].res);
    drain();
    for (int i = 0; i < N_RANDOM; i++) begin
      no_gaps = (i >= 300 && i < 450);
      if (i == 600) drain();
      rq = random_req();
      send_req(rq, 1'b0, '0);
    end
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_euler_angle_shortest_blend passed");
    end else begin
      $display("tb_euler_angle_shortest_blend failed");
    end
    $finish;
  end

  // result check and receiver stall pattern
  always @(posedge clk) begin : rx
    blend_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (blend_q.size() == 0) begin
        $error("unexpected transaction: x=%0d y=%0d z=%0d", out_x, out_y, out_z);
        errors++;
      end else begin
        want = blend_q.pop_front();
        if (out_x !== want.x) begin
          $error("out_x expected %0d actual %0d", want.x, out_x);
          errors++;
        end
        if (out_y !== want.y) begin
          $error("out_y expected %0d actual %0d", want.y, out_y);
          errors++;
        end
        if (out_z !== want.z) begin
          $error("out_z expected %0d actual %0d", want.z, out_z);
          errors++;
        end
      end
    end
    rx_count++;
    if (rx_count % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (rx_count % 16 == 0);
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_euler_angle_shortest_blend failed");
      $finish;
    end
  end

endmodule
